>>> rtl/utf8_stream_decoder_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define UTF8D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utf8d assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utf8d assertion failed");

`else

`define UTF8D_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/utf8d_pkg.sv
// Types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned COUNT_W = 16;

	// Character counter ceiling: the lesser of COUNT_MAX and the counter range
	localparam longint unsigned COUNT_MAX = 65535;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT =
		(COUNT_MAX > 65535) ? 16'hFFFF : COUNT_W'(COUNT_MAX);

	// Payload masks for lead and continuation bytes
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

	// Continuation bytes still expected after each lead form
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_TWO  = 2'd1;
	localparam logic [1:0] PEND_THREE = 2'd2;
	localparam logic [1:0] PEND_FOUR = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              is_last;
	} in_word_t;

	typedef struct packed {
		logic [CP_W-1:0]    code_point;
		logic               error;
		logic               end_of_string;
		logic [COUNT_W-1:0] char_count;
	} result_t;

endpackage

>>> rtl/utf8d_if.sv
// Handshake channels of the UTF-8 stream decoder: byte words in, character words out.
interface utf8d_byte_if import utf8d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;
	logic              is_last;

	modport source (output valid, output byte_in, output is_last, input ready);
	modport sink (input valid, input byte_in, input is_last, output ready);
endinterface

interface utf8d_char_if import utf8d_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CP_W-1:0]    code_point;
	logic               error;
	logic               end_of_string;
	logic [COUNT_W-1:0] char_count;

	modport source (output valid, output code_point, output error, output end_of_string,
		output char_count, input ready);
	modport sink (input valid, input code_point, input error, input end_of_string,
		input char_count, output ready);
endinterface

>>> rtl/utf8d_in_reg.sv
// Input register stage: captures one byte word per cycle while the stage can drain, and holds it until it advances.
module utf8d_in_reg import utf8d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	utf8d_byte_if.sink      din,
	input  logic            adv,
	output logic            valid_s1,
	output in_word_t        word_s1
);

	logic valid_q;

	// Take a new word when the stage is empty or drains this cycle
	assign din.ready = !valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (din.valid && din.ready) begin
			valid_q <= 1'b1;
		end else if (adv) begin
			valid_q <= 1'b0;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			word_s1.byte_in <= din.byte_in;
			word_s1.is_last <= din.is_last;
		end
	end

	assign valid_s1 = valid_q;

endmodule

>>> rtl/utf8d_decode.sv
// Decode logic and per-string state: sequence length, partial value, count, drop flag.
module utf8d_decode import utf8d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  in_word_t word_s1,
	output logic     res_valid,
	output result_t  res
);

	logic [1:0]         pending_q, pending_n;
	logic [CP_W-1:0]    value_q, value_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic               disc_q, disc_n;

	logic [CP_W-1:0]    shifted;
	logic [CP_W-1:0]    char_val;
	logic [COUNT_W-1:0] count_inc;
	logic [1:0]         pend_dec;
	logic               do_char, do_err, go_disc, is_lead, is_bad;
	logic [BYTE_W-1:0]  b;
	logic               last;

	assign b    = word_s1.byte_in;
	assign last = word_s1.is_last;

	// Merge six payload bits of a continuation byte
	assign shifted   = {value_q[CP_W-7:0], 6'(b & CONT_MASK)};
	assign pend_dec  = pending_q - 2'd1;
	assign count_inc = (count_q < COUNT_LIMIT) ? count_q + 16'd1 : count_q;

	always_comb begin
		pending_n = pending_q;
		value_n   = value_q;
		count_n   = count_q;
		disc_n    = disc_q;
		do_char   = 1'b0;
		do_err    = 1'b0;
		go_disc   = 1'b0;
		is_lead   = 1'b0;
		is_bad    = 1'b0;
		char_val  = '0;
		res_valid = 1'b0;
		res       = '0;

		// Classify the byte against the current sequence state
		if (disc_q) begin
			do_err = last;
		end else if (pending_q == PEND_NONE) begin
			if (b inside {[8'h00:8'h7F]}) begin
				do_char  = 1'b1;
				char_val = CP_W'(b);
			end else if (b inside {[8'hC0:8'hDF]}) begin
				is_lead   = 1'b1;
				value_n   = CP_W'(b & LEAD2_MASK);
				pending_n = PEND_TWO;
			end else if (b inside {[8'hE0:8'hEF]}) begin
				is_lead   = 1'b1;
				value_n   = CP_W'(b & LEAD3_MASK);
				pending_n = PEND_THREE;
			end else if (b inside {[8'hF0:8'hF7]}) begin
				is_lead   = 1'b1;
				value_n   = CP_W'(b & LEAD4_MASK);
				pending_n = PEND_FOUR;
			end else begin
				is_bad = 1'b1;
			end
			if ((is_lead || is_bad) && last) begin
				do_err = 1'b1;
			end else if (is_bad) begin
				go_disc = 1'b1;
			end
		end else begin
			if (pend_dec == PEND_NONE) begin
				do_char  = 1'b1;
				char_val = shifted;
			end else begin
				value_n   = shifted;
				pending_n = pend_dec;
				do_err    = last;
			end
		end

		// Emit a finished character; clear the string on its last byte
		if (do_char) begin
			res_valid         = 1'b1;
			res.code_point    = char_val;
			res.end_of_string = last;
			res.char_count    = count_inc;
			pending_n         = PEND_NONE;
			value_n           = '0;
			count_n           = last ? '0 : count_inc;
		end

		// Emit the closing error word and clear the string
		if (do_err) begin
			res_valid         = 1'b1;
			res.error         = 1'b1;
			res.end_of_string = 1'b1;
			pending_n         = PEND_NONE;
			value_n           = '0;
			count_n           = '0;
			disc_n            = 1'b0;
		end

		// Drop the rest of a malformed string
		if (go_disc) begin
			pending_n = PEND_NONE;
			value_n   = '0;
			disc_n    = 1'b1;
		end
	end

	// Advance state when the input stage hands over a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PEND_NONE;
			value_q   <= '0;
			count_q   <= '0;
			disc_q    <= 1'b0;
		end else if (adv) begin
			pending_q <= pending_n;
			value_q   <= value_n;
			count_q   <= count_n;
			disc_q    <= disc_n;
		end
	end

endmodule

>>> rtl/utf8d_out_reg.sv
// Result register: holds one character word until the sink takes it.
module utf8d_out_reg import utf8d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  result_t      res,
	output logic         free,
	utf8d_char_if.source dout
);

	logic    valid_q;
	result_t res_q;

	// Room for a new word when empty or when the held word leaves now
	assign free = !valid_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (dout.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign dout.valid         = valid_q;
	assign dout.code_point    = res_q.code_point;
	assign dout.error         = res_q.error;
	assign dout.end_of_string = res_q.end_of_string;
	assign dout.char_count    = res_q.char_count;

endmodule

>>> rtl/utf8_stream_decoder.sv
// Channel  Dir  Width  Contents
// din      in   8+1    byte_in, is_last
// dout     out  21+1+1+16  code_point, error, end_of_string, char_count
//
// One byte word per cycle while dout takes results; an accepted word waits in the
// input register and is decoded as it moves into the result register. Words that
// end no character produce nothing. Reset clears control and per-string state.
// A stall on dout holds the result register; the input register still takes
// one more word, then din.ready drops until dout drains.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder import utf8d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	utf8d_byte_if.sink   din,
	utf8d_char_if.source dout
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     adv;
	logic     free;
	logic     res_valid;
	result_t  res;

	// Advance the input stage when the result register has room
	assign adv = valid_s1 && free;

	utf8d_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	utf8d_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.word_s1   (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	utf8d_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && res_valid),
		.res    (res),
		.free   (free),
		.dout   (dout)
	);

	// An error word always closes the string with zero value and count
	`UTF8D_ASSERT_SAME(a_err_word, clk, arst_n, dout.valid && dout.error,
		dout.end_of_string && dout.code_point == '0 && dout.char_count == '0)

	// A stalled input word stays put
	`UTF8D_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(word_s1))

	// A decoded word reaches the output the next cycle
	`UTF8D_ASSERT_NEXT(a_res_load, clk, arst_n, adv && res_valid, dout.valid)

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the UTF-8 stream decoder: directed strings, random strings.
`timescale 1ns / 100ps

module tb_top;
	import utf8d_pkg::*;

	// Lead byte class boundaries
	localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
	localparam logic [BYTE_W-1:0] BAD_LEAD_MIN = 8'hF8;
	localparam logic [BYTE_W-1:0] CONT_MIN     = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_MAX     = 8'hBF;
	localparam int RANDOM_BYTES_PER_PHASE      = 450;
	localparam int LONG_STRING_BYTES           = 160;
	localparam int MAX_PRINTED                 = 100;

	logic clk;
	logic arst_n;

	utf8d_byte_if din_if ();
	utf8d_char_if dout_if ();

	utf8_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	// Decoder state mirrored by the predictor
	logic [1:0]         pend_cnt   = PEND_NONE;
	logic [CP_W-1:0]    part_val   = '0;
	logic [COUNT_W-1:0] char_seen  = '0;
	logic               discarding = 1'b0;

	result_t expected_chars[$];
	int      err_count = 0;
	int      idle_pct  = 0;
	int      stall_pct = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: drop ready at random per the current stall rate
	initial begin
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			dout_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (err_count < MAX_PRINTED)
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		err_count++;
	endtask

	// Advance the decoder state by one byte; return 1 when a character word is due
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic last,
			output result_t r);
		bit bad;
		bit done;
		bad  = 1'b0;
		done = 1'b0;
		r    = '0;
		if (discarding) begin
			if (!last)
				return 1'b0;
			bad = 1'b1;
		end else if (pend_cnt == PEND_NONE) begin
			if (b < CONT_MIN) begin
				part_val = CP_W'(b);
				done = 1'b1;
			end else if (b >= BAD_LEAD_MIN) begin
				bad = 1'b1;
			end else if (b >= LEAD4_MIN) begin
				part_val = CP_W'(b & LEAD4_MASK);
				pend_cnt = PEND_FOUR;
			end else if (b >= LEAD3_MIN) begin
				part_val = CP_W'(b & LEAD3_MASK);
				pend_cnt = PEND_THREE;
			end else if (b >= LEAD2_MIN) begin
				part_val = CP_W'(b & LEAD2_MASK);
				pend_cnt = PEND_TWO;
			end else begin
				bad = 1'b1;
			end
			// a lead byte that ends the string cuts its sequence off
			if (!done && !bad && last)
				bad = 1'b1;
		end else begin
			part_val = {part_val[CP_W-7:0], 6'(b & CONT_MASK)};
			pend_cnt = pend_cnt - 2'd1;
			if (pend_cnt == PEND_NONE)
				done = 1'b1;
			else if (last)
				bad = 1'b1;
		end

		if (bad) begin
			pend_cnt = PEND_NONE;
			part_val = '0;
			if (!last) begin
				discarding = 1'b1;
				return 1'b0;
			end
			r.error = 1'b1;
			r.end_of_string = 1'b1;
			char_seen  = '0;
			discarding = 1'b0;
			return 1'b1;
		end
		if (done) begin
			if (char_seen < COUNT_LIMIT)
				char_seen = char_seen + 1'b1;
			r.code_point = part_val;
			r.end_of_string = last;
			r.char_count = char_seen;
			part_val = '0;
			pend_cnt = PEND_NONE;
			if (last)
				char_seen = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Predict on every accepted byte word
	always @(posedge clk) begin
		result_t r;
		if (arst_n && din_if.valid && din_if.ready) begin
			if (decode_byte(din_if.byte_in, din_if.is_last, r))
				expected_chars.push_back(r);
		end
	end

	// Check every accepted character word against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (expected_chars.size() == 0) begin
				flag_mismatch("unexpected character word", dout_if.code_point, 0);
			end else begin
				want = expected_chars.pop_front();
				if (dout_if.code_point !== want.code_point)
					flag_mismatch("code_point", dout_if.code_point, want.code_point);
				if (dout_if.error !== want.error)
					flag_mismatch("error", dout_if.error, want.error);
				if (dout_if.end_of_string !== want.end_of_string)
					flag_mismatch("end_of_string", dout_if.end_of_string,
						want.end_of_string);
				if (dout_if.char_count !== want.char_count)
					flag_mismatch("char_count", dout_if.char_count, want.char_count);
			end
		end
	end

	// Send one byte word, idling first at the current sender rate
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid   <= 1'b1;
		din_if.byte_in <= b;
		din_if.is_last <= last;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
	endtask

	task automatic push_string(input logic [BYTE_W-1:0] s[$]);
		foreach (s[i])
			push_byte(s[i], i == s.size() - 1);
	endtask

	// Hold off until every predicted word has arrived, then let the pipe settle
	task automatic wait_drained();
		din_if.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic test_ascii_bytes();
		idle_pct  = 0;
		stall_pct = 0;
		push_string('{8'h00});
		push_string('{8'h7F});
		wait_drained();
	endtask

	task automatic test_well_formed_sequences();
		push_string('{8'hC0, 8'h80, 8'hDF, 8'hBF});
		push_string('{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF});
		push_string('{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF7, 8'hFF, 8'h3F, 8'hBF});
		wait_drained();
	endtask

	task automatic test_malformed_strings();
		// stray continuation on the last byte
		push_string('{8'h80});
		// bad lead mid-string, then discard up to the last byte
		push_string('{8'hF8, 8'h41});
		push_string('{8'hFF});
		// sequence cut off by the last byte
		push_string('{8'hE2, 8'h82});
		push_string('{8'hC3});
		// stray continuation mid-string
		push_string('{8'hBF, 8'h00});
		wait_drained();
	endtask

	// Run the counter past its ceiling when that is short, else over one long string
	task automatic test_long_string();
		int n;
		idle_pct  = 0;
		stall_pct = 0;
		n = int'(COUNT_LIMIT) + 3;
		if (n > LONG_STRING_BYTES)
			n = LONG_STRING_BYTES;
		for (int i = 0; i < n; i++)
			push_byte(8'h61, i == n - 1);
		wait_drained();
	endtask

	// Build one random character: mostly well formed, some noise and short sequences
	task automatic add_random_char(ref logic [BYTE_W-1:0] s[$]);
		int kind;
		int len;
		int conts;
		kind = $urandom_range(99);
		len  = $urandom_range(4, 1);
		if (kind < 6) begin
			s.push_back(8'($urandom_range(255)));
			return;
		end
		case (len)
			1: s.push_back(8'($urandom_range(8'h7F)));
			2: s.push_back(8'($urandom_range(8'hDF, LEAD2_MIN)));
			3: s.push_back(8'($urandom_range(8'hEF, LEAD3_MIN)));
			default: s.push_back(8'($urandom_range(8'hF7, LEAD4_MIN)));
		endcase
		conts = (kind < 12 && len > 1) ? $urandom_range(len - 2) : len - 1;
		repeat (conts) begin
			if ($urandom_range(99) < 90)
				s.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
			else
				s.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random_phase(input int idle, input int stall);
		logic [BYTE_W-1:0] s[$];
		int sent;
		int nchars;
		idle_pct  = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < RANDOM_BYTES_PER_PHASE) begin
			s = {};
			nchars = $urandom_range(8, 1);
			repeat (nchars)
				add_random_char(s);
			push_string(s);
			sent += s.size();
		end
		wait_drained();
	endtask

	task automatic test_random_strings();
		run_random_phase(0, 0);
		run_random_phase(52, 0);
		run_random_phase(0, 52);
		run_random_phase(16, 16);
	endtask

	initial begin
		arst_n         <= 1'b0;
		din_if.valid   <= 1'b0;
		din_if.byte_in <= '0;
		din_if.is_last <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii_bytes();
		test_well_formed_sequences();
		test_malformed_strings();
		test_random_strings();
		test_long_string();

		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> utf8_stream_decoder.f
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_if.sv
rtl/utf8d_in_reg.sv
rtl/utf8d_decode.sv
rtl/utf8d_out_reg.sv
rtl/utf8_stream_decoder.sv
test/tb_top.sv
